>>> hw/rtl/brkl_pkg.sv
// Shared types and constants for the bounded recency key list.
// Depends on nothing; every other file but brkl_ram imports it.
package brkl_pkg;

  localparam int KEY_W        = 64;
  localparam int LIMIT_W      = 7;
  localparam int OCC_W        = 7;
  localparam int CAPACITY_DEF = 64;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [1:0] REQ_PREPEND = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_FIND    = 2'd2;
  localparam logic [1:0] REQ_POP     = 2'd3;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] req_key;
  } req_t;

  typedef struct packed {
    logic             key_found;
    logic [KEY_W-1:0] out_key;
    logic             out_key_valid;
    logic             status;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic cur_tail;
    logic rd_cur;
    logic step;
    logic set_found;
    logic set_out_key;
    logic set_status;
    logic unlink;
    logic rd_free;
    logic alloc_fresh;
    logic alloc_pop;
    logic link_head;
    logic ins_write;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       need_evict;
    logic       is_empty;
    logic       walk_done;
    logic       match;
    logic       free_avail;
  } stat_t;

endpackage

>>> hw/rtl/bounded_recency_key_list.sv
// Bounded recency key list: top level joining controller and datapath.
// Depends on brkl_pkg, brkl_ctrl, brkl_dpath (and brkl_ram below it).
//
// Keeps up to CAPACITY 64-bit keys as a doubly linked list, newest at the
// head, oldest at the tail. One transaction carries one request (prepend,
// remove, find, pop) and produces exactly one result transaction. Requests
// are processed one at a time: a new request is taken only once the previous
// one has finished its work, though a finished result may still sit in the
// output register waiting for the consumer. Remove and find walk the list
// from the head through the single-read-port slot memories, visiting at most
// as many entries as the list holds; prepend unlinks the tail first when the
// list is at its limit, and pop unlinks the tail. Slots are recycled through
// a free-slot stack plus a fresh-slot counter, so no clearing pass is needed
// after reset.
// capacity_limit may be written only while the block is idle; 0 acts as 1
// and values above CAPACITY act as CAPACITY.
module bounded_recency_key_list #(
  parameter int CAPACITY = brkl_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  brkl_pkg::req_t               in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output brkl_pkg::rsp_t               out_data,
  input  logic                         cfg_wr_en,
  input  logic [brkl_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import brkl_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencing only; no payload passes through here
  brkl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .st(st), .cmd(cmd)
  );

  // memories, pointers, config register and result register
  brkl_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .cmd(cmd), .st(st), .out_data(out_data)
  );
endmodule

>>> hw/rtl/brkl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brkl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata <= mem_r[raddr];
  end
endmodule

>>> hw/rtl/brkl_dpath.sv
// Datapath: slot memories, free-slot stack, list pointers and result registers.
// Depends on brkl_pkg and brkl_ram.
module brkl_dpath #(
  parameter int CAPACITY = brkl_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  brkl_pkg::req_t                in_data,
  input  logic                          cfg_wr_en,
  input  logic [brkl_pkg::LIMIT_W-1:0]  cfg_wr_data,
  input  brkl_pkg::cmd_t                cmd,
  output brkl_pkg::stat_t               st,
  output brkl_pkg::rsp_t                out_data
);
  import brkl_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = IDX_W + LIMIT_W;
  localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

  logic [IDX_W-1:0]   head_r, tail_r, count_r, fresh_r, free_cnt_r;
  logic [IDX_W-1:0]   cur_r, steps_r, new_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [KEY_W-1:0]   key_r, okey_r;
  logic [1:0]         type_r;
  logic               found_r, okv_r, status_r;
  rsp_t               out_data_r;

  logic [KEY_W-1:0] key_rdata;
  logic [IDX_W-1:0] next_rdata, prev_rdata;
  logic [AW-1:0]    free_rdata;
  logic [IDX_W-1:0] free_top;

  logic             next_we, prev_we;
  logic [IDX_W-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;

  logic [CW-1:0] lim_w, lim_eff, occ_w;

  assign free_top = free_cnt_r - IDX_W'(1);

  // next-pointer writes: unlink bypass or new node
  always_comb begin
    next_we    = 1'b0;
    next_waddr = new_r;
    next_wdata = head_r;
    if (cmd.unlink) begin
      next_we    = (prev_rdata != NIL);
      next_waddr = prev_rdata;
      next_wdata = next_rdata;
    end else if (cmd.ins_write) begin
      next_we = 1'b1;
    end
  end

  always_comb begin
    prev_we    = 1'b0;
    prev_waddr = new_r;
    prev_wdata = NIL;
    if (cmd.unlink) begin
      prev_we    = (next_rdata != NIL);
      prev_waddr = next_rdata;
      prev_wdata = prev_rdata;
    end else if (cmd.link_head) begin
      prev_we    = (head_r != NIL);
      prev_waddr = head_r;
      prev_wdata = new_r;
    end else if (cmd.ins_write) begin
      prev_we = 1'b1;
    end
  end

  brkl_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk(clk), .we(cmd.ins_write), .waddr(new_r[AW-1:0]), .wdata(key_r),
    .re(cmd.rd_cur), .raddr(cur_r[AW-1:0]), .rdata(key_rdata)
  );

  brkl_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_waddr[AW-1:0]), .wdata(next_wdata),
    .re(cmd.rd_cur), .raddr(cur_r[AW-1:0]), .rdata(next_rdata)
  );

  brkl_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_waddr[AW-1:0]), .wdata(prev_wdata),
    .re(cmd.rd_cur), .raddr(cur_r[AW-1:0]), .rdata(prev_rdata)
  );

  // free-slot stack, pushed on unlink
  brkl_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .we(cmd.unlink), .waddr(free_cnt_r[AW-1:0]), .wdata(cur_r[AW-1:0]),
    .re(cmd.rd_free), .raddr(free_top[AW-1:0]), .rdata(free_rdata)
  );

  // limit clamped to 1..CAPACITY
  assign lim_w   = CW'(limit_r);
  assign lim_eff = (limit_r == '0) ? CW'(1) :
                   (lim_w > CW'(CAPACITY)) ? CW'(CAPACITY) : lim_w;
  assign occ_w   = CW'(count_r);

  assign st.req_type   = type_r;
  assign st.need_evict = (count_r != '0) && (occ_w >= lim_eff);
  assign st.is_empty   = (count_r == '0);
  assign st.walk_done  = (steps_r == count_r);
  assign st.match      = (key_rdata == key_r);
  assign st.free_avail = (free_cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= NIL;
      tail_r     <= NIL;
      count_r    <= '0;
      fresh_r    <= '0;
      free_cnt_r <= '0;
      limit_r    <= LIMIT_RESET;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (cmd.unlink) begin
        if (prev_rdata == NIL) head_r <= next_rdata;
        if (next_rdata == NIL) tail_r <= prev_rdata;
        count_r    <= count_r - IDX_W'(1);
        free_cnt_r <= free_cnt_r + IDX_W'(1);
      end
      if (cmd.alloc_fresh) fresh_r <= fresh_r + IDX_W'(1);
      if (cmd.alloc_pop) free_cnt_r <= free_top;
      if (cmd.ins_write) begin
        head_r  <= new_r;
        if (head_r == NIL) tail_r <= new_r;
        count_r <= count_r + IDX_W'(1);
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= in_data.req_key;
      type_r   <= in_data.req_type;
      cur_r    <= head_r;
      steps_r  <= '0;
      found_r  <= 1'b0;
      okey_r   <= '0;
      okv_r    <= 1'b0;
      status_r <= STATUS_OK;
    end
    if (cmd.cur_tail) cur_r <= tail_r;
    if (cmd.step) begin
      cur_r   <= next_rdata;
      steps_r <= steps_r + IDX_W'(1);
    end
    if (cmd.set_found) found_r <= 1'b1;
    if (cmd.set_out_key) begin
      okey_r <= key_rdata;
      okv_r  <= 1'b1;
    end
    if (cmd.set_status) status_r <= STATUS_EMPTY;
    if (cmd.alloc_fresh) new_r <= fresh_r;
    if (cmd.alloc_pop) new_r <= IDX_W'(free_rdata);
    if (cmd.out_load) begin
      out_data_r.key_found     <= found_r;
      out_data_r.out_key       <= okey_r;
      out_data_r.out_key_valid <= okv_r;
      out_data_r.status        <= status_r;
      out_data_r.occupancy     <= occ_w[OCC_W-1:0];
    end
  end

  assign out_data = out_data_r;
endmodule

>>> hw/rtl/brkl_ctrl.sv
// Controller state machine: sequences one request through the datapath.
// Depends on brkl_pkg.
module brkl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  brkl_pkg::stat_t st,
  output brkl_pkg::cmd_t  cmd
);
  import brkl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_WALK_RD, S_WALK_CHK, S_EV_RD, S_EV_UNL,
    S_ALLOC, S_ALLOC_WAIT, S_LINK, S_WRITE, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (st.req_type)
          REQ_PREPEND: begin
            if (st.need_evict) begin
              cmd.cur_tail = 1'b1;
              state_nxt    = S_EV_RD;
            end else begin
              state_nxt = S_ALLOC;
            end
          end
          REQ_REMOVE, REQ_FIND: state_nxt = S_WALK_RD;
          default: begin
            if (st.is_empty) begin
              cmd.set_status = 1'b1;
              state_nxt      = S_DONE;
            end else begin
              cmd.cur_tail = 1'b1;
              state_nxt    = S_EV_RD;
            end
          end
        endcase
      end
      S_WALK_RD: begin
        if (st.walk_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_nxt  = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (st.match) begin
          cmd.set_found = 1'b1;
          cmd.unlink    = (st.req_type == REQ_REMOVE);
          state_nxt     = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_WALK_RD;
        end
      end
      S_EV_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_EV_UNL;
      end
      S_EV_UNL: begin
        cmd.set_out_key = 1'b1;
        cmd.unlink      = 1'b1;
        state_nxt       = (st.req_type == REQ_PREPEND) ? S_ALLOC : S_DONE;
      end
      S_ALLOC: begin
        if (st.free_avail) begin
          cmd.rd_free = 1'b1;
          state_nxt   = S_ALLOC_WAIT;
        end else begin
          cmd.alloc_fresh = 1'b1;
          state_nxt       = S_LINK;
        end
      end
      S_ALLOC_WAIT: begin
        cmd.alloc_pop = 1'b1;
        state_nxt     = S_LINK;
      end
      S_LINK: begin
        cmd.link_head = 1'b1;
        state_nxt     = S_WRITE;
      end
      S_WRITE: begin
        cmd.ins_write = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

>>> hw/rtl/brkl_chk.sv
// Port-level checker for the bounded recency key list, bound to the top level.
// Depends on brkl_pkg and bounded_recency_key_list.
module brkl_chk #(
  parameter int CAPACITY = brkl_pkg::CAPACITY_DEF
) (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input brkl_pkg::rsp_t out_data
);
  import brkl_pkg::*;

  localparam int CHK_W = OCC_W + 12;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CHK_W'(out_data.occupancy) <= CHK_W'(CAPACITY)))
    else $error("occupancy above capacity");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_EMPTY) |->
      !out_data.out_key_valid && (out_data.occupancy == '0))
    else $error("empty status with key or entries");

  a_found_key_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.key_found && out_data.out_key_valid))
    else $error("found and key valid together");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
endmodule

bind bounded_recency_key_list brkl_chk #(.CAPACITY(CAPACITY)) u_brkl_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
